// ===== hdl/pit_pkg.sv =====
// ============================================================================
// pit_pkg: shared definitions for the pulse interval tachometer
// widths, reset values, scale constants and codes used by the top level
// and the shared divider
// ============================================================================
package pit_pkg;

    // history depth default
    localparam int HISTORY_DEPTH_DEF = 100;

    // field widths
    localparam int IVW    = 16;   // interval in ms
    localparam int WINW   = 4;    // window count
    localparam int POLLW  = 29;   // poll period in ns
    localparam int RATEW  = 20;   // rate, q8
    localparam int SUMW   = 20;   // sum of up to 15 intervals
    localparam int CFGIW  = 2;    // config register index
    localparam int CFGDW  = 29;   // config write data

    // divider widths
    localparam int DIVW   = 36;   // dividend and quotient
    localparam int DVSW   = 20;   // divisor
    localparam int RSCW   = 22;   // rate scale times window count

    // stream widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 56;

    // reset values
    localparam logic [IVW-1:0]   STALL_RESET    = 16'd2000;
    localparam logic [IVW-1:0]   MIN_RESET      = 16'd40;
    localparam logic [WINW-1:0]  WIN_RESET      = 4'd15;
    localparam logic [POLLW-1:0] MAX_POLL_RESET = 29'd500000000;

    // scale constants
    localparam logic [RSCW-WINW-1:0] RATE_SCALE = 18'd256000;
    localparam logic [15:0]          POLL_SCALE = 16'd50000;

    // config register indexes
    localparam logic [CFGIW-1:0] CFG_STALL    = 2'd0;
    localparam logic [CFGIW-1:0] CFG_MIN      = 2'd1;
    localparam logic [CFGIW-1:0] CFG_WINDOW   = 2'd2;
    localparam logic [CFGIW-1:0] CFG_MAX_POLL = 2'd3;

    // event kinds
    localparam logic FUNC_PULSE   = 1'b0;
    localparam logic FUNC_TIMEOUT = 1'b1;

    // request to the shared divider
    typedef struct packed {
        logic            start;
        logic [DIVW-1:0] dividend;
        logic [DVSW-1:0] divisor;
    } div_req_t;

endpackage

// ===== hdl/pulse_interval_tachometer.sv =====
// ============================================================================
// pulse_interval_tachometer: period-averaging tachometer
// keeps a circular history of pulse intervals, averages the newest
// qualifying ones and reports a q8 rotation rate and a poll period
// ============================================================================
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid / s_tready  tdata: interval_ms; tuser: func
//  m_        out        m_tvalid / m_tready  tdata: rate_q8, poll_period_ns
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  an item passes through a scan, the divisions and the output register:
//  the scan reads one history entry per cycle from the single read port
//  and stops once window_count entries qualify or all entries are read;
//  the two divisions share one divider at one quotient bit per cycle; the
//  output register is loaded once no earlier result waits there. a stall
//  skips the scan and the divisions, an empty window skips the divisions
//  and a zero rate skips the poll division.
//  synchronous active-low reset; history slots count as empty after reset
//  through one written bit per slot, so no clearing pass is needed.
//  s_tready is high only while idle; a result waits in the output register
//  while the next item is accepted. config is always ready.
// ============================================================================
module pulse_interval_tachometer #(
    parameter int HISTORY_DEPTH = pit_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pit_pkg::S_TDATA_W-1:0]   s_tdata,   // [15:0] interval_ms
    input  logic                            s_tuser,   // [0] func
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pit_pkg::M_TDATA_W-1:0]   m_tdata,   // [19:0] rate_q8,
                                                       // [48:20] poll_period_ns,
                                                       // [55:49] zero
    // register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pit_pkg::CFGIW-1:0]       cfg_index,
    input  logic [pit_pkg::CFGDW-1:0]       cfg_data
);

    localparam int AW   = $clog2(HISTORY_DEPTH);       // slot address
    localparam int IW   = $clog2(HISTORY_DEPTH + 1);   // scan index, holds depth
    localparam int ADDW = IW + 1;                      // head plus index

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_RATE = 3'd2;
    localparam logic [2:0] ST_RDIV = 3'd3;
    localparam logic [2:0] ST_POLL = 3'd4;
    localparam logic [2:0] ST_PDIV = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    // history store and its written bits
    logic [pit_pkg::IVW-1:0]    hist_mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0]   written_reg;

    // control
    logic [2:0]                 state_reg, state_next;
    logic [AW-1:0]              head_reg, head_next;
    logic [IW-1:0]              idx_reg, idx_next;
    logic                       pend_reg, pend_next;
    logic [pit_pkg::WINW-1:0]   n_reg, n_next;
    logic [pit_pkg::SUMW-1:0]   sum_reg, sum_next;
    logic                       m_valid_reg, m_valid_next;

    // registers
    logic [pit_pkg::IVW-1:0]    stall_reg;
    logic [pit_pkg::IVW-1:0]    min_reg;
    logic [pit_pkg::WINW-1:0]   win_reg;
    logic [pit_pkg::POLLW-1:0]  max_poll_reg;

    // working results and output register
    logic [pit_pkg::RATEW-1:0]  rate_reg, rate_next;
    logic [pit_pkg::POLLW-1:0]  poll_reg, poll_next;
    logic [pit_pkg::RATEW-1:0]  m_rate_reg, m_rate_next;
    logic [pit_pkg::POLLW-1:0]  m_poll_reg, m_poll_next;

    // read port
    logic [pit_pkg::IVW-1:0]    rd_data_reg;
    logic                       rd_written_reg;
    logic [ADDW-1:0]            addr_sum;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic                       wr_en;
    logic                       qual;

    // shared divider
    pit_pkg::div_req_t          div_req;
    logic                       div_done;
    logic [pit_pkg::DIVW-1:0]   div_q;
    logic [pit_pkg::RSCW-1:0]   rate_num;
    logic [pit_pkg::DIVW-1:0]   poll_num;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign wr_en     = s_tvalid && s_tready;

    // pulse moves the head back one slot over the oldest entry
    assign head_next = (wr_en && s_tuser == pit_pkg::FUNC_PULSE)
                       ? ((head_reg == '0) ? AW'(HISTORY_DEPTH - 1) : head_reg - AW'(1))
                       : head_reg;
    assign wr_addr   = head_next;

    // logical entry idx lives at head + idx, wrapped
    assign addr_sum = ADDW'(head_reg) + ADDW'(idx_reg);
    assign rd_addr  = (addr_sum >= ADDW'(HISTORY_DEPTH))
                      ? AW'(addr_sum - ADDW'(HISTORY_DEPTH)) : AW'(addr_sum);

    // entry returned by the previous read counts towards the window if written and above the minimum
    assign qual = pend_reg && rd_written_reg && (rd_data_reg > min_reg);

    // constant products feeding the divider load registers
    assign rate_num = pit_pkg::RSCW'(pit_pkg::RATE_SCALE) * pit_pkg::RSCW'(n_reg);
    assign poll_num = pit_pkg::DIVW'(pit_pkg::POLL_SCALE) * pit_pkg::DIVW'(sum_reg);

    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        pend_next        = pend_reg;
        n_next           = n_reg;
        sum_next         = sum_reg;
        rate_next        = rate_reg;
        poll_next        = poll_reg;
        m_valid_next     = m_valid_reg;
        m_rate_next      = m_rate_reg;
        m_poll_next      = m_poll_reg;
        div_req.start    = 1'b0;
        div_req.dividend = pit_pkg::DIVW'(rate_num);
        div_req.divisor  = sum_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (wr_en) begin
                    rate_next = '0;
                    poll_next = max_poll_reg;
                    idx_next  = '0;
                    pend_next = 1'b0;
                    n_next    = '0;
                    sum_next  = '0;
                    // stall: newest interval above the limit
                    if (s_tdata[pit_pkg::IVW-1:0] > stall_reg) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (n_reg >= win_reg) begin
                    state_next = ST_RATE;
                end else begin
                    if (qual) begin
                        n_next   = n_reg + pit_pkg::WINW'(1);
                        sum_next = sum_reg + pit_pkg::SUMW'(rd_data_reg);
                    end
                    if (idx_reg == IW'(HISTORY_DEPTH) && !pend_reg) begin
                        state_next = ST_RATE;
                    end else begin
                        pend_next = (idx_reg < IW'(HISTORY_DEPTH));
                        if (idx_reg < IW'(HISTORY_DEPTH)) begin
                            idx_next = idx_reg + IW'(1);
                        end
                    end
                end
            end
            ST_RATE: begin
                if (n_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = ST_RDIV;
                end
            end
            ST_RDIV: begin
                if (div_done) begin
                    rate_next = div_q[pit_pkg::RATEW-1:0];
                    if (div_q == '0) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_POLL;
                    end
                end
            end
            ST_POLL: begin
                div_req.start    = 1'b1;
                div_req.dividend = poll_num;
                div_req.divisor  = pit_pkg::DVSW'(n_reg);
                state_next       = ST_PDIV;
            end
            ST_PDIV: begin
                if (div_done) begin
                    if (div_q > pit_pkg::DIVW'(max_poll_reg)) begin
                        poll_next = max_poll_reg;
                    end else begin
                        poll_next = div_q[pit_pkg::POLLW-1:0];
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // wait for the output register to be free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_rate_next  = rate_reg;
                    m_poll_next  = poll_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            written_reg  <= '0;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            n_reg        <= '0;
            sum_reg      <= '0;
            m_valid_reg  <= 1'b0;
            stall_reg    <= pit_pkg::STALL_RESET;
            min_reg      <= pit_pkg::MIN_RESET;
            win_reg      <= pit_pkg::WIN_RESET;
            max_poll_reg <= pit_pkg::MAX_POLL_RESET;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            n_reg       <= n_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
            if (wr_en) begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    pit_pkg::CFG_STALL:    stall_reg    <= cfg_data[pit_pkg::IVW-1:0];
                    pit_pkg::CFG_MIN:      min_reg      <= cfg_data[pit_pkg::IVW-1:0];
                    pit_pkg::CFG_WINDOW:   win_reg      <= cfg_data[pit_pkg::WINW-1:0];
                    pit_pkg::CFG_MAX_POLL: max_poll_reg <= cfg_data[pit_pkg::POLLW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rate_reg   <= rate_next;
        poll_reg   <= poll_next;
        m_rate_reg <= m_rate_next;
        m_poll_reg <= m_poll_next;
    end

    // history memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hist_mem[wr_addr] <= s_tdata[pit_pkg::IVW-1:0];
        end
        rd_data_reg    <= hist_mem[rd_addr];
        rd_written_reg <= written_reg[rd_addr];
    end

    pit_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(pit_pkg::M_TDATA_W - pit_pkg::RATEW - pit_pkg::POLLW)'(0),
                       m_poll_reg, m_rate_reg};

endmodule

// ===== hdl/pit_div.sv =====
// ============================================================================
// pit_div: shared restoring divider
// unsigned division, one quotient bit per cycle, done pulses for one cycle
// ============================================================================
module pit_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pit_pkg::div_req_t              req,
    output logic                           done,
    output logic [pit_pkg::DIVW-1:0]       quotient
);

    localparam int CW = $clog2(pit_pkg::DIVW + 1);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic [pit_pkg::DVSW-1:0]   rem_reg, rem_next;
    logic [pit_pkg::DIVW-1:0]   quo_reg, quo_next;
    logic [pit_pkg::DVSW-1:0]   dvs_reg, dvs_next;
    logic [pit_pkg::DVSW:0]     rem_sh;
    logic [pit_pkg::DVSW:0]     diff;

    // shifted partial remainder and trial subtract
    assign rem_sh = {rem_reg, quo_reg[pit_pkg::DIVW-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(pit_pkg::DIVW);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            if (!diff[pit_pkg::DVSW]) begin
                rem_next = diff[pit_pkg::DVSW-1:0];
                quo_next = {quo_reg[pit_pkg::DIVW-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[pit_pkg::DVSW-1:0];
                quo_next = {quo_reg[pit_pkg::DIVW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
